/* sv/pidaw_pkg.sv */
package pidaw_pkg;

	// field widths
	localparam int unsigned LuxW   = 16;
	localparam int unsigned GainW  = 24;
	localparam int unsigned PoleW  = 16;
	localparam int unsigned DriveW = 12;
	localparam int unsigned ErrW   = 17;
	localparam int unsigned AccW   = 48;
	localparam int unsigned WindW  = 32;
	localparam int unsigned CfgW   = 24;

	// setpoint weight, Q8 (256 = full weight)
	localparam int unsigned SETPOINT_WEIGHT_Q8 = 256;

	// register reset values
	localparam logic [LuxW-1:0]   RST_REFERENCE   = 16'd560;
	localparam logic [GainW-1:0]  RST_PROP_GAIN   = 24'd65536;
	localparam logic [GainW-1:0]  RST_INT_GAIN    = 24'd0;
	localparam logic [PoleW-1:0]  RST_DERIV_POLE  = 16'd0;
	localparam logic [GainW-1:0]  RST_DERIV_GAIN  = 24'd0;
	localparam logic [GainW-1:0]  RST_WINDUP_GAIN = 24'd88474;
	localparam logic [DriveW-1:0] RST_ACT_MIN     = 12'd0;
	localparam logic [DriveW-1:0] RST_ACT_MAX     = 12'd255;

	// accumulator saturation bounds
	localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};

	// configuration register map
	typedef enum logic [2:0] {
		REG_REFERENCE   = 3'd0,
		REG_PROP_GAIN   = 3'd1,
		REG_INT_GAIN    = 3'd2,
		REG_DERIV_POLE  = 3'd3,
		REG_DERIV_GAIN  = 3'd4,
		REG_WINDUP_GAIN = 3'd5,
		REG_ACT_MIN     = 3'd6,
		REG_ACT_MAX     = 3'd7
	} cfg_reg_t;

	// clamp result code
	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_HIGH = 2'd1,
		CLAMP_LOW  = 2'd2
	} clamp_t;

endpackage

/* sv/pidaw_sample_if.sv */
interface pidaw_sample_if;
	logic                          valid;
	logic                          ready;
	logic [pidaw_pkg::LuxW-1:0]    measured_lux;

	modport source (output valid, output measured_lux, input ready);
	modport sink (input valid, input measured_lux, output ready);
endinterface

/* sv/pidaw_drive_if.sv */
interface pidaw_drive_if;
	logic                          valid;
	logic                          ready;
	logic [pidaw_pkg::DriveW-1:0]  drive;
	pidaw_pkg::clamp_t             clamp_state;

	modport source (output valid, output drive, output clamp_state, input ready);
	modport sink (input valid, input drive, input clamp_state, output ready);
endinterface

/* sv/pid_antiwindup_controller_core.sv */
// PID controller with back-calculation anti-windup for a light actuator.
// sample channel (sink): one measured light level per transaction, Q12.4.
// command channel (source): clamped drive value and clamp code per sample.
// cfg port: write enable, register index and data; the user must write
// registers only while no sample is in flight, not enforced by the core.
// A sample taken is held in the input register; once the result register
// is free, P, I and D are computed, rounded and clamped and the result
// register is loaded, which makes the command valid.
// Throughput is one sample per cycle while the command receiver takes
// results; the integrator, derivative filter and windup error update in
// the same edge that loads the result register, closing the recurrence.
// When the command receiver stalls, the result register holds, the input
// register holds one more sample, and the sample channel drops ready once
// both are full.
// Reset clears the pipeline valids and all controller state, and loads the
// registers with their defaults (reference 560, Kp 1.0, windup gain 1.35,
// drive limits 0 to 255).
module pid_antiwindup_controller_core #(
	parameter int unsigned SETPOINT_WEIGHT_Q8 = pidaw_pkg::SETPOINT_WEIGHT_Q8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pidaw_sample_if.sink                  sample,
	pidaw_drive_if.source                 command,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [pidaw_pkg::CfgW-1:0]    cfg_data
);

	// configuration registers
	logic [pidaw_pkg::LuxW-1:0]           reference_q;
	logic signed [pidaw_pkg::GainW-1:0]   prop_gain_q;
	logic signed [pidaw_pkg::GainW-1:0]   int_gain_q;
	logic [pidaw_pkg::PoleW-1:0]          deriv_pole_q;
	logic signed [pidaw_pkg::GainW-1:0]   deriv_gain_q;
	logic signed [pidaw_pkg::GainW-1:0]   windup_gain_q;
	logic [pidaw_pkg::DriveW-1:0]         act_min_q;
	logic [pidaw_pkg::DriveW-1:0]         act_max_q;

	// input stage
	logic                                 valid_s1;
	logic [pidaw_pkg::LuxW-1:0]           lux_s1;

	// controller state
	logic [pidaw_pkg::LuxW-1:0]           last_sample_q;
	logic signed [pidaw_pkg::ErrW-1:0]    last_error_q;
	logic signed [pidaw_pkg::AccW-1:0]    integral_q;
	logic signed [pidaw_pkg::AccW-1:0]    deriv_q;
	logic signed [pidaw_pkg::WindW-1:0]   windup_q;

	// result register
	logic                                 out_valid_q;
	logic [pidaw_pkg::DriveW-1:0]         drive_q;
	pidaw_pkg::clamp_t                    clamp_q;

	logic                                 advance;

	// datapath
	logic [24:0]                          ref_w;
	logic signed [25:0]                   p_diff;
	logic signed [49:0]                   p_prod;
	logic signed [41:0]                   p_term;
	logic signed [pidaw_pkg::ErrW-1:0]    err;
	logic signed [17:0]                   err_sum;
	logic signed [41:0]                   ki_prod;
	logic signed [55:0]                   kw_prod;
	logic signed [60:0]                   i_raw;
	logic signed [pidaw_pkg::AccW-1:0]    i_sat;
	logic signed [64:0]                   pole_prod;
	logic signed [48:0]                   pole_term;
	logic signed [16:0]                   lux_diff;
	logic signed [40:0]                   kd_prod;
	logic signed [49:0]                   d_raw;
	logic signed [pidaw_pkg::AccW-1:0]    d_sat;
	logic signed [49:0]                   pid_sum;
	logic signed [49:0]                   pid_rnd;
	logic signed [29:0]                   raw;
	logic signed [29:0]                   hi_s;
	logic signed [29:0]                   lo_s;
	logic [pidaw_pkg::DriveW-1:0]         drive_next;
	pidaw_pkg::clamp_t                    clamp_next;
	logic signed [pidaw_pkg::WindW-1:0]   windup_next;

	// handshake: input register moves when the result register is free
	assign advance       = !out_valid_q || command.ready;
	assign sample.ready  = !valid_s1 || advance;
	assign command.valid = out_valid_q;
	assign command.drive = drive_q;
	assign command.clamp_state = clamp_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q   <= pidaw_pkg::RST_REFERENCE;
			prop_gain_q   <= pidaw_pkg::RST_PROP_GAIN;
			int_gain_q    <= pidaw_pkg::RST_INT_GAIN;
			deriv_pole_q  <= pidaw_pkg::RST_DERIV_POLE;
			deriv_gain_q  <= pidaw_pkg::RST_DERIV_GAIN;
			windup_gain_q <= pidaw_pkg::RST_WINDUP_GAIN;
			act_min_q     <= pidaw_pkg::RST_ACT_MIN;
			act_max_q     <= pidaw_pkg::RST_ACT_MAX;
		end else if (cfg_we) begin
			case (pidaw_pkg::cfg_reg_t'(cfg_index))
				pidaw_pkg::REG_REFERENCE:   reference_q   <= cfg_data[15:0];
				pidaw_pkg::REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				pidaw_pkg::REG_INT_GAIN:    int_gain_q    <= cfg_data;
				pidaw_pkg::REG_DERIV_POLE:  deriv_pole_q  <= cfg_data[15:0];
				pidaw_pkg::REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				pidaw_pkg::REG_WINDUP_GAIN: windup_gain_q <= cfg_data;
				pidaw_pkg::REG_ACT_MIN:     act_min_q     <= cfg_data[11:0];
				pidaw_pkg::REG_ACT_MAX:     act_max_q     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// proportional term with setpoint weighting, Q.28 floored to Q.20
	always_comb begin
		ref_w  = 25'(SETPOINT_WEIGHT_Q8) * 25'(reference_q);
		p_diff = $signed({1'b0, ref_w}) - $signed({2'b00, lux_s1, 8'h00});
		p_prod = 50'(prop_gain_q) * 50'(p_diff);
		p_term = p_prod[49:8];
	end

	// trapezoidal integral plus back-calculation
	always_comb begin
		err     = $signed({1'b0, reference_q}) - $signed({1'b0, lux_s1});
		err_sum = $signed({err[16], err}) + $signed({last_error_q[16], last_error_q});
		ki_prod = 42'(int_gain_q) * 42'(err_sum);
		kw_prod = 56'(windup_gain_q) * 56'(windup_q);
		i_raw   = 61'(integral_q) + 61'(ki_prod) + 61'($signed({kw_prod, 4'h0}));
		if (i_raw[60:47] != {14{i_raw[60]}})
			i_sat = i_raw[60] ? pidaw_pkg::ACC_MIN : pidaw_pkg::ACC_MAX;
		else
			i_sat = i_raw[47:0];
	end

	// filtered derivative on the measurement
	always_comb begin
		pole_prod = 65'($signed({1'b0, deriv_pole_q})) * 65'(deriv_q);
		pole_term = pole_prod[64:16];
		lux_diff  = $signed({1'b0, lux_s1}) - $signed({1'b0, last_sample_q});
		kd_prod   = 41'(deriv_gain_q) * 41'(lux_diff);
		d_raw     = 50'(pole_term) - 50'(kd_prod);
		if (d_raw[49:47] != {3{d_raw[49]}})
			d_sat = d_raw[49] ? pidaw_pkg::ACC_MIN : pidaw_pkg::ACC_MAX;
		else
			d_sat = d_raw[47:0];
	end

	// round half up, clamp, windup error
	always_comb begin
		pid_sum = 50'(p_term) + 50'(i_sat) + 50'(d_sat);
		pid_rnd = pid_sum + 50'sd524288;
		raw     = pid_rnd[49:20];
		hi_s    = $signed({18'd0, act_max_q});
		lo_s    = $signed({18'd0, act_min_q});
		if (raw > hi_s) begin
			drive_next  = act_max_q;
			clamp_next  = pidaw_pkg::CLAMP_HIGH;
			windup_next = $signed({{2{hi_s[29]}}, hi_s}) - $signed({{2{raw[29]}}, raw});
		end else if (raw < lo_s) begin
			drive_next  = act_min_q;
			clamp_next  = pidaw_pkg::CLAMP_LOW;
			windup_next = $signed({{2{lo_s[29]}}, lo_s}) - $signed({{2{raw[29]}}, raw});
		end else begin
			drive_next  = raw[11:0];
			clamp_next  = pidaw_pkg::CLAMP_NONE;
			windup_next = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready)
			lux_s1 <= sample.measured_lux;
	end

	// controller state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			last_sample_q <= '0;
			last_error_q  <= '0;
			integral_q    <= '0;
			deriv_q       <= '0;
			windup_q      <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				last_sample_q <= lux_s1;
				last_error_q  <= err;
				integral_q    <= i_sat;
				deriv_q       <= d_sat;
				windup_q      <= windup_next;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_q <= drive_next;
			clamp_q <= clamp_next;
		end
	end

	// an accepted sample always lands in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> valid_s1)
		else $error("accepted sample not held in input register");

	// a blocked input stage keeps its sample
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(lux_s1))
		else $error("input stage sample lost under stall");

	// windup error is cleared whenever the pending result is unclamped
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clamp_q == pidaw_pkg::CLAMP_NONE |-> windup_q == '0)
		else $error("windup error set without clamping");

	// windup error sign follows the clamp direction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clamp_q == pidaw_pkg::CLAMP_HIGH |-> windup_q[31])
		else $error("high clamp with non-negative windup error");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clamp_q == pidaw_pkg::CLAMP_LOW |-> !windup_q[31] && windup_q != '0)
		else $error("low clamp with non-positive windup error");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int          HOLD_CYCLES = 48;
	localparam int          CYCLE_LIMIT = 100000;
	localparam longint      WIND_MAX    = 64'sh7FFF_FFFF;
	localparam longint      WIND_MIN    = -WIND_MAX - 1;

	typedef struct {
		logic [pidaw_pkg::DriveW-1:0] drive;
		pidaw_pkg::clamp_t            clamp_state;
	} drive_cmd_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [2:0]                    cfg_index;
	logic [pidaw_pkg::CfgW-1:0]    cfg_data;

	pidaw_sample_if sample_ch();
	pidaw_drive_if  command_ch();

	pid_antiwindup_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.command   (command_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// controller settings as last written
	logic [pidaw_pkg::LuxW-1:0]          ref_level;
	logic signed [pidaw_pkg::GainW-1:0]  kp_gain;
	logic signed [pidaw_pkg::GainW-1:0]  ki_gain;
	logic [pidaw_pkg::PoleW-1:0]         pole_q16;
	logic signed [pidaw_pkg::GainW-1:0]  kd_gain;
	logic signed [pidaw_pkg::GainW-1:0]  kw_gain;
	logic [pidaw_pkg::DriveW-1:0]        act_min;
	logic [pidaw_pkg::DriveW-1:0]        act_max;

	// controller history
	logic [pidaw_pkg::LuxW-1:0]          prev_lux;
	logic signed [pidaw_pkg::ErrW-1:0]   prev_err;
	logic signed [pidaw_pkg::AccW-1:0]   integ_acc;
	logic signed [pidaw_pkg::AccW-1:0]   deriv_acc;
	logic signed [pidaw_pkg::WindW-1:0]  windup_err;

	drive_cmd_t drive_expect_q[$];
	int         fail_count  = 0;
	int         cycle_count = 0;
	bit         no_gaps     = 1'b0;
	bit         hold_req    = 1'b0;
	int         hold_left   = 0;

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// one control step: P + I + D, round half up, clamp, update history
	function automatic drive_cmd_t predict_command(input logic [pidaw_pkg::LuxW-1:0] lux);
		longint     lx, err, p_term, i_term, d_term, raw, lo, hi, wind;
		drive_cmd_t cmd;
		lx  = longint'(lux);
		err = longint'(ref_level) - lx;
		p_term = (longint'(kp_gain) *
			(longint'(pidaw_pkg::SETPOINT_WEIGHT_Q8) * longint'(ref_level) - 256 * lx)) >>> 8;
		i_term = clip(longint'(integ_acc) + longint'(ki_gain) * (err + longint'(prev_err))
			+ longint'(kw_gain) * longint'(windup_err) * 16,
			longint'(pidaw_pkg::ACC_MIN), longint'(pidaw_pkg::ACC_MAX));
		d_term = clip(((longint'(pole_q16) * longint'(deriv_acc)) >>> 16)
			- longint'(kd_gain) * (lx - longint'(prev_lux)),
			longint'(pidaw_pkg::ACC_MIN), longint'(pidaw_pkg::ACC_MAX));
		raw = (p_term + i_term + d_term + (longint'(1) <<< 19)) >>> 20;
		lo  = longint'(act_min);
		hi  = longint'(act_max);
		// high limit wins when the limits are crossed
		if (raw > hi) begin
			cmd.drive       = act_max;
			cmd.clamp_state = pidaw_pkg::CLAMP_HIGH;
			wind            = clip(hi - raw, WIND_MIN, WIND_MAX);
		end else if (raw < lo) begin
			cmd.drive       = act_min;
			cmd.clamp_state = pidaw_pkg::CLAMP_LOW;
			wind            = clip(lo - raw, WIND_MIN, WIND_MAX);
		end else begin
			cmd.drive       = raw[pidaw_pkg::DriveW-1:0];
			cmd.clamp_state = pidaw_pkg::CLAMP_NONE;
			wind            = 0;
		end
		prev_lux   = lux;
		prev_err   = err[pidaw_pkg::ErrW-1:0];
		integ_acc  = i_term[pidaw_pkg::AccW-1:0];
		deriv_acc  = d_term[pidaw_pkg::AccW-1:0];
		windup_err = wind[pidaw_pkg::WindW-1:0];
		return cmd;
	endfunction

	// register write; unused upper data bits carry random junk
	task automatic write_reg(input pidaw_pkg::cfg_reg_t idx,
		input logic [pidaw_pkg::CfgW-1:0] value);
		logic [pidaw_pkg::CfgW-1:0] wdata;
		logic [31:0]                junk;
		wdata = value;
		junk  = $urandom;
		case (idx)
			pidaw_pkg::REG_REFERENCE: begin
				wdata[pidaw_pkg::CfgW-1:pidaw_pkg::LuxW] =
					junk[pidaw_pkg::CfgW-pidaw_pkg::LuxW-1:0];
				ref_level = wdata[pidaw_pkg::LuxW-1:0];
			end
			pidaw_pkg::REG_PROP_GAIN:   kp_gain = wdata[pidaw_pkg::GainW-1:0];
			pidaw_pkg::REG_INT_GAIN:    ki_gain = wdata[pidaw_pkg::GainW-1:0];
			pidaw_pkg::REG_DERIV_POLE: begin
				wdata[pidaw_pkg::CfgW-1:pidaw_pkg::PoleW] =
					junk[pidaw_pkg::CfgW-pidaw_pkg::PoleW-1:0];
				pole_q16 = wdata[pidaw_pkg::PoleW-1:0];
			end
			pidaw_pkg::REG_DERIV_GAIN:  kd_gain = wdata[pidaw_pkg::GainW-1:0];
			pidaw_pkg::REG_WINDUP_GAIN: kw_gain = wdata[pidaw_pkg::GainW-1:0];
			pidaw_pkg::REG_ACT_MIN: begin
				wdata[pidaw_pkg::CfgW-1:pidaw_pkg::DriveW] =
					junk[pidaw_pkg::CfgW-pidaw_pkg::DriveW-1:0];
				act_min = wdata[pidaw_pkg::DriveW-1:0];
			end
			pidaw_pkg::REG_ACT_MAX: begin
				wdata[pidaw_pkg::CfgW-1:pidaw_pkg::DriveW] =
					junk[pidaw_pkg::CfgW-pidaw_pkg::DriveW-1:0];
				act_max = wdata[pidaw_pkg::DriveW-1:0];
			end
			default: ;
		endcase
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = wdata;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one sample transaction, with an optional random gap ahead of it
	task automatic send_sample(input logic [pidaw_pkg::LuxW-1:0] lux);
		if (!no_gaps) begin
			while ($urandom_range(0, 99) < 10) begin
				sample_ch.valid = 1'b0;
				@(negedge clk);
			end
		end
		sample_ch.valid        = 1'b1;
		sample_ch.measured_lux = lux;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		drive_expect_q.push_back(predict_command(lux));
		@(negedge clk);
	endtask

	// stop offering samples and let every pending command come back
	task automatic wait_idle();
		sample_ch.valid = 1'b0;
		while (drive_expect_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_sample(16'd560);
	endtask

	// narrow limits, with samples that clamp high and low; then full-scale max
	task automatic test_clamping();
		wait_idle();
		write_reg(pidaw_pkg::REG_REFERENCE, 24'd4000);
		write_reg(pidaw_pkg::REG_ACT_MIN, 24'd10);
		write_reg(pidaw_pkg::REG_ACT_MAX, 24'd200);
		send_sample(16'd4000);
		send_sample(16'd0);
		send_sample(16'd2000);
		send_sample(16'hFFFF);
		wait_idle();
		write_reg(pidaw_pkg::REG_ACT_MAX, 24'h000FFF);
		write_reg(pidaw_pkg::REG_REFERENCE, 24'h00FFFF);
		send_sample(16'd0);
	endtask

	// min above max: the high check comes first
	task automatic test_crossed_limits();
		wait_idle();
		write_reg(pidaw_pkg::REG_ACT_MIN, 24'd3000);
		write_reg(pidaw_pkg::REG_ACT_MAX, 24'd1000);
		send_sample(16'd0);
		send_sample(16'hFFFF);
		send_sample(16'd30000);
	endtask

	// zero back-calculation gain, integrator left to wind up
	task automatic test_windup_off();
		wait_idle();
		write_reg(pidaw_pkg::REG_WINDUP_GAIN, 24'd0);
		write_reg(pidaw_pkg::REG_INT_GAIN, 24'd6554);
		write_reg(pidaw_pkg::REG_ACT_MIN, 24'd0);
		write_reg(pidaw_pkg::REG_ACT_MAX, 24'd255);
		send_sample(16'd0);
		send_sample(16'd0);
		send_sample(16'd0);
	endtask

	// maximum gains make the integrator swing into both saturation bounds
	task automatic test_integrator_saturation();
		wait_idle();
		write_reg(pidaw_pkg::REG_PROP_GAIN, 24'h7FFFFF);
		write_reg(pidaw_pkg::REG_INT_GAIN, 24'h7FFFFF);
		write_reg(pidaw_pkg::REG_WINDUP_GAIN, 24'h7FFFFF);
		repeat (5) send_sample(16'd0);
	endtask

	// full-pole derivative filter with both extreme gains
	task automatic test_derivative_filter();
		wait_idle();
		write_reg(pidaw_pkg::REG_PROP_GAIN, 24'd0);
		write_reg(pidaw_pkg::REG_INT_GAIN, 24'd0);
		write_reg(pidaw_pkg::REG_WINDUP_GAIN, 24'd0);
		write_reg(pidaw_pkg::REG_DERIV_POLE, 24'h00FFFF);
		write_reg(pidaw_pkg::REG_DERIV_GAIN, 24'h7FFFFF);
		send_sample(16'd0);
		send_sample(16'hFFFF);
		wait_idle();
		write_reg(pidaw_pkg::REG_DERIV_GAIN, 24'h800000);
		send_sample(16'd0);
		send_sample(16'hFFFF);
	endtask

	// command receiver holds off while samples keep coming
	task automatic test_backpressure();
		wait_idle();
		no_gaps  = 1'b1;
		hold_req = 1'b1;
		repeat (16) send_sample(16'($urandom));
		no_gaps = 1'b0;
	endtask

	// phases of random settings, extremes first; samples mostly near the target
	task automatic test_random_traffic();
		int                          span;
		int                          v;
		logic [pidaw_pkg::LuxW-1:0]  lux;
		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					write_reg(pidaw_pkg::REG_REFERENCE, 24'h00FFFF);
					write_reg(pidaw_pkg::REG_PROP_GAIN, 24'h7FFFFF);
					write_reg(pidaw_pkg::REG_INT_GAIN, 24'h7FFFFF);
					write_reg(pidaw_pkg::REG_DERIV_POLE, 24'h00FFFF);
					write_reg(pidaw_pkg::REG_DERIV_GAIN, 24'h7FFFFF);
					write_reg(pidaw_pkg::REG_WINDUP_GAIN, 24'h7FFFFF);
					write_reg(pidaw_pkg::REG_ACT_MIN, 24'h000FFF);
					write_reg(pidaw_pkg::REG_ACT_MAX, 24'h000FFF);
				end
				1: begin
					write_reg(pidaw_pkg::REG_REFERENCE, 24'd0);
					write_reg(pidaw_pkg::REG_PROP_GAIN, 24'h800000);
					write_reg(pidaw_pkg::REG_INT_GAIN, 24'h800000);
					write_reg(pidaw_pkg::REG_DERIV_POLE, 24'd0);
					write_reg(pidaw_pkg::REG_DERIV_GAIN, 24'h800000);
					write_reg(pidaw_pkg::REG_WINDUP_GAIN, 24'h800000);
					write_reg(pidaw_pkg::REG_ACT_MIN, 24'd0);
					write_reg(pidaw_pkg::REG_ACT_MAX, 24'd0);
				end
				default: begin
					write_reg(pidaw_pkg::REG_REFERENCE, 24'($urandom_range(0, 65535)));
					write_reg(pidaw_pkg::REG_PROP_GAIN,
						24'($urandom_range(0, 196608) - 65536));
					write_reg(pidaw_pkg::REG_INT_GAIN, 24'($urandom_range(0, 4000) - 1000));
					write_reg(pidaw_pkg::REG_DERIV_POLE, 24'($urandom_range(0, 65535)));
					write_reg(pidaw_pkg::REG_DERIV_GAIN,
						24'($urandom_range(0, 131072) - 65536));
					write_reg(pidaw_pkg::REG_WINDUP_GAIN,
						24'($urandom_range(0, 200000) - 20000));
					write_reg(pidaw_pkg::REG_ACT_MIN, 24'($urandom_range(0, 1500)));
					write_reg(pidaw_pkg::REG_ACT_MAX, 24'($urandom_range(0, 4095)));
				end
			endcase
			// one phase runs without any idle cycles on either side
			no_gaps = (phase == 3);
			span    = $urandom_range(64, 4096);
			repeat (110) begin
				if ($urandom_range(0, 9) < 7) begin
					v = int'(ref_level) + int'($urandom_range(0, 2 * span)) - span;
					if (v < 0)
						v = 0;
					if (v > 65535)
						v = 65535;
					lux = v[pidaw_pkg::LuxW-1:0];
				end else begin
					lux = 16'($urandom_range(0, 65535));
				end
				send_sample(lux);
			end
			no_gaps = 1'b0;
		end
	endtask

	// command receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			command_ch.ready = 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req         = 1'b0;
			hold_left        = HOLD_CYCLES - 1;
			command_ch.ready = 1'b0;
		end else begin
			command_ch.ready = no_gaps || ($urandom_range(0, 99) >= 10);
		end
	end

	// compare each command transaction with the oldest prediction
	always @(posedge clk) begin : check_commands
		drive_cmd_t want;
		if (arst_n && command_ch.valid && command_ch.ready) begin
			if (drive_expect_q.size() == 0) begin
				$error("command transaction with no sample pending: drive %0d",
					command_ch.drive);
				fail_count++;
			end else begin
				want = drive_expect_q.pop_front();
				if (command_ch.drive !== want.drive) begin
					$error("drive: expected %0d, got %0d", want.drive, command_ch.drive);
					fail_count++;
				end
				if (command_ch.clamp_state !== want.clamp_state) begin
					$error("clamp_state: expected %0d, got %0d",
						want.clamp_state, command_ch.clamp_state);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.measured_lux = '0;
		command_ch.ready       = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = pidaw_pkg::REG_REFERENCE;
		cfg_data               = '0;
		// settings and history as after reset
		ref_level  = pidaw_pkg::RST_REFERENCE;
		kp_gain    = pidaw_pkg::RST_PROP_GAIN;
		ki_gain    = pidaw_pkg::RST_INT_GAIN;
		pole_q16   = pidaw_pkg::RST_DERIV_POLE;
		kd_gain    = pidaw_pkg::RST_DERIV_GAIN;
		kw_gain    = pidaw_pkg::RST_WINDUP_GAIN;
		act_min    = pidaw_pkg::RST_ACT_MIN;
		act_max    = pidaw_pkg::RST_ACT_MAX;
		prev_lux   = '0;
		prev_err   = '0;
		integ_acc  = '0;
		deriv_acc  = '0;
		windup_err = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_clamping();
		test_crossed_limits();
		test_windup_off();
		test_integrator_saturation();
		test_derivative_filter();
		test_backpressure();
		test_random_traffic();

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
